// ----- rtl/additive_hash_linear_probe_table_top_assert.svh -----
// assertion macros for the additive hash table top level
// expects clk and rst_n in the including scope
`ifndef ADDITIVE_HASH_LINEAR_PROBE_TABLE_TOP_ASSERT_SVH
`define ADDITIVE_HASH_LINEAR_PROBE_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define AHLP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ahlp assertion failed");
`define AHLP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ahlp assertion failed");
`else
`define AHLP_ASSERT_IMP(lbl, ante, cons)
`define AHLP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/ahlp_pkg.sv -----
// shared constants, codes and types of the additive hash table
// no dependencies
`default_nettype none
package ahlp_pkg;

    localparam int TABLE_SLOTS    = 256;
    localparam int SLOT_W         = $clog2(TABLE_SLOTS);
    localparam int SIZE_W         = 9;
    localparam int MAX_WORD_BYTES = 8;
    localparam int CHARS_W        = 64;
    localparam int LEN_W          = 4;
    localparam int SUM_W          = $clog2(MAX_WORD_BYTES * 255 + 1);
    localparam int STEP_W         = $clog2(SUM_W);
    localparam int ENTRY_W        = CHARS_W + LEN_W;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    localparam logic [ADDR_W-3:0] REG_SIZE = '0;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_READ     = 2'd2;

    typedef struct packed {
        logic               kind;
        logic               zero_len;
        logic [CHARS_W-1:0] chars;
        logic [LEN_W-1:0]   length;
        logic [SUM_W-1:0]   sum;
        logic [7:0]         read_slot;
    } queue_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         slot_index;
        logic [CHARS_W-1:0] chars;
        logic [LEN_W-1:0]   length;
        logic               occupied;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/additive_hash_linear_probe_table_top.sv -----
// an insert passes the queue, the modulo unit and a probe of p slots, p = slots probed (1..size);
// a read passes the queue and the registered slot ram; an empty-word insert is answered from idle;
// the engine takes one item at a time, set by the 11-step modulo unit, the one-slot-per-cycle probe
// and the wait for a free result register; a two-beat queue lets the front keep accepting meanwhile
// reset: asynchronous, all occupancy flags clear at once, size register to 256,
// stored words undefined until written
// depends on ahlp_pkg, ahlp_front, ahlp_queue, ahlp_back and the assertion macro header
`default_nettype none
`include "additive_hash_linear_probe_table_top_assert.svh"
module additive_hash_linear_probe_table_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ahlp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ahlp_pkg::DATA_W-1:0]  pwdata,
    output logic      [ahlp_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire logic                         kind,
    input  wire logic [ahlp_pkg::CHARS_W-1:0] word_chars,
    input  wire logic [ahlp_pkg::LEN_W-1:0]   word_length,
    input  wire logic [7:0]                   read_slot,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output logic      [1:0]                   status,
    output logic      [7:0]                   slot_index,
    output logic      [ahlp_pkg::CHARS_W-1:0] slot_chars,
    output logic      [ahlp_pkg::LEN_W-1:0]   slot_length,
    output logic                              slot_occupied
);
    import ahlp_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    logic [SIZE_W-1:0] size_eff;
    logic              cfg_write;
    logic              push;
    queue_item_t       push_item;
    queue_item_t       head;
    logic              queue_empty;
    logic              queue_full;
    logic              pop;
    result_t           result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[ADDR_W-1:2] == REG_SIZE);
    assign size_next = cfg_write ? pwdata[SIZE_W-1:0] : size_reg;
    assign prdata    = (paddr[ADDR_W-1:2] == REG_SIZE) ? DATA_W'(size_reg) : '0;

    // zero acts as one, anything past the store acts as the full store
    always_comb
    begin
        if (size_reg == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (size_reg > SIZE_W'(TABLE_SLOTS))
        begin
            size_eff = SIZE_W'(TABLE_SLOTS);
        end
        else
        begin
            size_eff = size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(TABLE_SLOTS);
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    ahlp_front u_front (
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .kind        (kind),
        .word_chars  (word_chars),
        .word_length (word_length),
        .read_slot   (read_slot),
        .queue_full  (queue_full),
        .push        (push),
        .push_item   (push_item)
    );

    ahlp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    ahlp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .size_eff     (size_eff),
        .head         (head),
        .empty        (queue_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign status        = result.status;
    assign slot_index    = result.slot_index;
    assign slot_chars    = result.chars;
    assign slot_length   = result.length;
    assign slot_occupied = result.occupied;

    // a free slot read and every insert result carry no word
    `AHLP_ASSERT_IMP(a_free_read_blank, result_valid && !slot_occupied,
                     (slot_chars == '0) && (slot_length == '0))
    `AHLP_ASSERT_IMP(a_insert_blank, result_valid && (status != ST_READ),
                     !slot_occupied && (slot_chars == '0) && (slot_length == '0))
    `AHLP_ASSERT_IMP(a_insert_in_range, result_valid && (status == ST_INSERTED),
                     ({1'b0, slot_index} < size_eff))
    `AHLP_ASSERT_NXT(a_size_write, cfg_write, size_reg == $past(pwdata[SIZE_W-1:0]))

endmodule
`default_nettype wire

// ----- rtl/ahlp_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module ahlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/ahlp_front.sv -----
// front end: takes an item, clamps the length, masks the bytes and sums them
// depends on ahlp_pkg
`default_nettype none
module ahlp_front (
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire logic                        kind,
    input  wire logic [ahlp_pkg::CHARS_W-1:0] word_chars,
    input  wire logic [ahlp_pkg::LEN_W-1:0]  word_length,
    input  wire logic [7:0]                  read_slot,
    input  wire logic                        queue_full,
    output logic                             push,
    output ahlp_pkg::queue_item_t            push_item
);
    import ahlp_pkg::*;

    logic [LEN_W-1:0]   len_c;
    logic [SUM_W-1:0]   sum;
    logic [CHARS_W-1:0] kept;
    logic [7:0]         byte_v;

    always_comb
    begin
        len_c = (word_length > LEN_W'(MAX_WORD_BYTES)) ? LEN_W'(MAX_WORD_BYTES) : word_length;
        sum    = '0;
        kept   = '0;
        byte_v = '0;
        for (int k = 0; k < MAX_WORD_BYTES; k++)
        begin
            byte_v = word_chars[8*k +: 8];
            if (LEN_W'(k) < len_c)
            begin
                sum = sum + SUM_W'(byte_v);
                kept[8*k +: 8] = byte_v;
            end
        end
    end

    assign item_ready = !queue_full;
    assign push       = item_valid && !queue_full;

    always_comb
    begin
        push_item.kind      = kind;
        push_item.zero_len  = (len_c == '0);
        push_item.chars     = kept;
        push_item.length    = len_c;
        push_item.sum       = sum;
        push_item.read_slot = read_slot;
    end

endmodule
`default_nettype wire

// ----- rtl/ahlp_queue.sv -----
// short queue between the front end and the table engine
// depends on ahlp_pkg
`default_nettype none
module ahlp_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire ahlp_pkg::queue_item_t push_item,
    input  wire logic                  pop,
    output ahlp_pkg::queue_item_t      head,
    output logic                       empty,
    output logic                       full
);
    import ahlp_pkg::*;

    queue_item_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ahlp_back.sv -----
// table engine: modulo unit, linear probe over occupancy flags, slot ram, result register
// depends on ahlp_pkg and ahlp_ram
`default_nettype none
module ahlp_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [ahlp_pkg::SIZE_W-1:0] size_eff,
    input  wire ahlp_pkg::queue_item_t      head,
    input  wire logic                       empty,
    output logic                            pop,
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output ahlp_pkg::result_t               result
);
    import ahlp_pkg::*;

    localparam logic [1:0] BK_IDLE  = 2'd0;
    localparam logic [1:0] BK_READ  = 2'd1;
    localparam logic [1:0] BK_MOD   = 2'd2;
    localparam logic [1:0] BK_PROBE = 2'd3;
    localparam int         DSH_W    = SUM_W + SIZE_W;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_reg;
    result_t                out_next;
    logic                   out_load;
    logic [TABLE_SLOTS-1:0] used_reg;
    logic [TABLE_SLOTS-1:0] used_next;

    logic [SUM_W-1:0]       rem_reg;
    logic [SUM_W-1:0]       rem_next;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;
    logic [CHARS_W-1:0]     chars_reg;
    logic [CHARS_W-1:0]     chars_next;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic [SIZE_W-1:0]      slot_reg;
    logic [SIZE_W-1:0]      slot_next;
    logic [SLOT_W-1:0]      home_reg;
    logic [SLOT_W-1:0]      home_next;
    logic [SIZE_W-1:0]      probes_reg;
    logic [SIZE_W-1:0]      probes_next;
    logic [7:0]             rd_slot_reg;
    logic [7:0]             rd_slot_next;
    logic                   rd_occ_reg;
    logic                   rd_occ_next;

    logic [DSH_W-1:0]       dsh;
    logic [SUM_W-1:0]       rem_step;
    logic [SLOT_W-1:0]      probe_idx;
    logic [SIZE_W-1:0]      slot_inc;
    logic [SIZE_W-1:0]      probes_inc;
    logic                   ram_we;
    logic [ENTRY_W-1:0]     ram_rdata;

    // one restoring step of sum mod size per cycle
    assign dsh      = DSH_W'(size_eff) << step_reg;
    assign rem_step = (DSH_W'(rem_reg) >= dsh) ? rem_reg - dsh[SUM_W-1:0] : rem_reg;

    assign probe_idx  = slot_reg[SLOT_W-1:0];
    assign slot_inc   = slot_reg + 1'b1;
    assign probes_inc = probes_reg + 1'b1;

    assign pop          = (state_reg == BK_IDLE) && !empty && !out_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    ahlp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (probe_idx),
        .wdata ({len_reg, chars_reg}),
        .raddr (head.read_slot[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        chars_next   = chars_reg;
        len_next     = len_reg;
        slot_next    = slot_reg;
        home_next    = home_reg;
        probes_next  = probes_reg;
        rd_slot_next = rd_slot_reg;
        rd_occ_next  = rd_occ_reg;
        out_load     = 1'b0;
        out_next     = out_reg;
        ram_we       = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    if (head.kind == KIND_READ)
                    begin
                        rd_slot_next = head.read_slot;
                        rd_occ_next  = used_reg[head.read_slot[SLOT_W-1:0]];
                        state_next   = BK_READ;
                    end
                    else if (head.zero_len)
                    begin
                        // empty word reports its home slot, which is zero
                        out_load = 1'b1;
                        out_next = '{status: ST_INSERTED, slot_index: '0, chars: '0,
                                     length: '0, occupied: 1'b0};
                    end
                    else
                    begin
                        rem_next   = head.sum;
                        step_next  = STEP_W'(SUM_W - 1);
                        chars_next = head.chars;
                        len_next   = head.length;
                        state_next = BK_MOD;
                    end
                end
            end
            BK_READ:
            begin
                out_load   = 1'b1;
                out_next   = '{status: ST_READ, slot_index: rd_slot_reg,
                               chars: rd_occ_reg ? ram_rdata[CHARS_W-1:0] : '0,
                               length: rd_occ_reg ? ram_rdata[ENTRY_W-1:CHARS_W] : '0,
                               occupied: rd_occ_reg};
                state_next = BK_IDLE;
            end
            BK_MOD:
            begin
                rem_next  = rem_step;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    home_next   = rem_step[SLOT_W-1:0];
                    slot_next   = rem_step[SIZE_W-1:0];
                    probes_next = '0;
                    state_next  = BK_PROBE;
                end
            end
            BK_PROBE:
            begin
                if (!used_reg[probe_idx])
                begin
                    used_next[probe_idx] = 1'b1;
                    ram_we     = 1'b1;
                    out_load   = 1'b1;
                    out_next   = '{status: ST_INSERTED, slot_index: 8'(probe_idx), chars: '0,
                                   length: '0, occupied: 1'b0};
                    state_next = BK_IDLE;
                end
                else if (probes_inc == size_eff)
                begin
                    out_load   = 1'b1;
                    out_next   = '{status: ST_FULL, slot_index: 8'(home_reg), chars: '0,
                                   length: '0, occupied: 1'b0};
                    state_next = BK_IDLE;
                end
                else
                begin
                    slot_next   = (slot_inc == size_eff) ? '0 : slot_inc;
                    probes_next = probes_inc;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            used_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        chars_reg   <= chars_next;
        len_reg     <= len_next;
        slot_reg    <= slot_next;
        home_reg    <= home_next;
        probes_reg  <= probes_next;
        rd_slot_reg <= rd_slot_next;
        rd_occ_reg  <= rd_occ_next;
    end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for additive_hash_linear_probe_table_top: directed table, then
// random inserts and reads over several table sizes, checked against a slot-table predictor
// depends on ahlp_pkg and the rtl top level
`timescale 1ns / 100ps
module tb_top;
    import ahlp_pkg::*;

    localparam int NUM_DIRECTED    = 23;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 108;
    localparam int LONG_HOLD       = 200;
    localparam int SETTLE_CYCLES   = 300;
    localparam int DRAIN_LIMIT     = 200000;

    localparam logic [ADDR_W-1:0] SIZE_ADDR = {REG_SIZE, 2'b00};
    localparam result_t NO_RESULT = '0;

    typedef struct packed {
        logic               kind;
        logic [CHARS_W-1:0] chars;
        logic [LEN_W-1:0]   length;
        logic [7:0]         read_slot;
        logic               hand_checked;
        result_t            want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                item_valid;
    logic                item_ready;
    logic                kind;
    logic [CHARS_W-1:0]  word_chars;
    logic [LEN_W-1:0]    word_length;
    logic [7:0]          read_slot;
    logic                result_valid;
    logic                result_ready;
    logic [1:0]          status;
    logic [7:0]          slot_index;
    logic [CHARS_W-1:0]  slot_chars;
    logic [LEN_W-1:0]    slot_length;
    logic                slot_occupied;

    // predictor state
    logic [CHARS_W-1:0]  stored_words [TABLE_SLOTS];
    logic [LEN_W-1:0]    stored_lengths [TABLE_SLOTS];
    bit                  slot_taken [TABLE_SLOTS];
    int unsigned         taken_slots [$];
    logic [SIZE_W-1:0]   size_setting = 9'd256;

    result_t             expected_results [$];
    int                  mismatch_count = 0;
    bit                  quiet_phase = 1'b0;
    bit                  long_hold_req = 1'b0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        // empty word: home slot 0, nothing stored
        '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 8'hFF, 1'b1,
          '{ST_INSERTED, 8'd0, 64'd0, 4'd0, 1'b0}},
        '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 8'h00, 1'b1,
          '{ST_INSERTED, 8'd248, 64'd0, 4'd0, 1'b0}},
        '{KIND_READ, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 8'd248, 1'b1,
          '{ST_READ, 8'd248, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1}},
        // overlong length counts as eight bytes, collides with slot 248
        '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 8'h00, 1'b1,
          '{ST_INSERTED, 8'd249, 64'd0, 4'd0, 1'b0}},
        '{KIND_READ, 64'h0, 4'd0, 8'd249, 1'b1,
          '{ST_READ, 8'd249, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1}},
        // bytes past the length are dropped from hash and store
        '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FF41, 4'd1, 8'h00, 1'b1,
          '{ST_INSERTED, 8'd65, 64'd0, 4'd0, 1'b0}},
        '{KIND_READ, 64'h0, 4'd0, 8'd65, 1'b1,
          '{ST_READ, 8'd65, 64'h41, 4'd1, 1'b1}},
        '{KIND_INSERT, 64'h0, 4'd8, 8'h00, 1'b1,
          '{ST_INSERTED, 8'd0, 64'd0, 4'd0, 1'b0}},
        '{KIND_READ, 64'h0, 4'd0, 8'd0, 1'b1,
          '{ST_READ, 8'd0, 64'd0, 4'd8, 1'b1}},
        '{KIND_INSERT, 64'hFF, 4'd1, 8'h00, 1'b1,
          '{ST_INSERTED, 8'd255, 64'd0, 4'd0, 1'b0}},
        // probe wraps past the last slot to slot 1
        '{KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAFF, 4'd1, 8'h00, 1'b1,
          '{ST_INSERTED, 8'd1, 64'd0, 4'd0, 1'b0}},
        '{KIND_READ, 64'h0, 4'd0, 8'd1, 1'b1,
          '{ST_READ, 8'd1, 64'hFF, 4'd1, 1'b1}},
        '{KIND_READ, 64'h0, 4'd0, 8'd255, 1'b1,
          '{ST_READ, 8'd255, 64'hFF, 4'd1, 1'b1}},
        '{KIND_INSERT, 64'h0102_0304_0506_0708, 4'd8, 8'h5A, 1'b0, NO_RESULT},
        '{KIND_INSERT, 64'h0102_0304_0506_0708, 4'd4, 8'hA5, 1'b0, NO_RESULT},
        '{KIND_INSERT, 64'h8000_0000_0000_0000, 4'd8, 8'h00, 1'b0, NO_RESULT},
        '{KIND_INSERT, 64'h7F7F_7F7F_7F7F_7F7F, 4'd9, 8'h00, 1'b0, NO_RESULT},
        '{KIND_INSERT, 64'hDEAD_BEEF_CAFE_F00D, 4'd3, 8'h00, 1'b0, NO_RESULT},
        '{KIND_READ, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 8'd36, 1'b0, NO_RESULT},
        '{KIND_READ, 64'h0, 4'd0, 8'd128, 1'b0, NO_RESULT},
        '{KIND_INSERT, 64'h1234, 4'd0, 8'h00, 1'b0, NO_RESULT},
        '{KIND_INSERT, 64'hFFFF, 4'd2, 8'h00, 1'b0, NO_RESULT},
        '{KIND_READ, 64'h0, 4'd0, 8'd254, 1'b0, NO_RESULT}
    };

    logic [SIZE_W-1:0] phase_sizes [NUM_PHASES] = '{
        9'd1, 9'd0, 9'd2, 9'd37, 9'd511, 9'd200, 9'd256, 9'd5, 9'd129, 9'd256
    };

    additive_hash_linear_probe_table_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .kind          (kind),
        .word_chars    (word_chars),
        .word_length   (word_length),
        .read_slot     (read_slot),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .status        (status),
        .slot_index    (slot_index),
        .slot_chars    (slot_chars),
        .slot_length   (slot_length),
        .slot_occupied (slot_occupied)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("additive_hash_linear_probe_table_top regression: fail");
        $finish;
    end

    // slot table outcome for one accepted beat; updates the predicted table on inserts
    function automatic result_t table_outcome(logic k, logic [CHARS_W-1:0] chars,
                                              logic [LEN_W-1:0] len_in, logic [7:0] rslot);
        result_t     res;
        int unsigned size_now;
        int unsigned nbytes;
        int unsigned sum;
        int unsigned home;
        int unsigned probe;
        int unsigned cnt;
        int unsigned b;
        logic [CHARS_W-1:0] kept;
        res = '0;
        if (k == KIND_READ)
        begin
            res.status     = ST_READ;
            res.slot_index = rslot;
            if (slot_taken[rslot])
            begin
                res.chars    = stored_words[rslot];
                res.length   = stored_lengths[rslot];
                res.occupied = 1'b1;
            end
            return res;
        end
        size_now = size_setting;
        if (size_now == 0)
            size_now = 1;
        if (size_now > TABLE_SLOTS)
            size_now = TABLE_SLOTS;
        nbytes = (len_in > MAX_WORD_BYTES) ? MAX_WORD_BYTES : len_in;
        sum  = 0;
        kept = '0;
        for (b = 0; b < nbytes; b++)
        begin
            sum += chars[8*b +: 8];
            kept[8*b +: 8] = chars[8*b +: 8];
        end
        home = sum % size_now;
        res.status     = ST_INSERTED;
        res.slot_index = 8'(home);
        if (nbytes == 0)
            return res;
        for (cnt = 0; cnt < size_now; cnt++)
        begin
            probe = (home + cnt) % size_now;
            if (!slot_taken[probe])
            begin
                slot_taken[probe]     = 1'b1;
                stored_words[probe]   = kept;
                stored_lengths[probe] = LEN_W'(nbytes);
                taken_slots = {taken_slots, probe};
                res.slot_index = 8'(probe);
                return res;
            end
        end
        res.status = ST_FULL;
        return res;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void take_result();
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result beat with nothing expected, slot_index 0x%0h", slot_index);
            mismatch_count++;
            return;
        end
        want = expected_results.pop_front();
        check_field("status", want.status, status);
        check_field("slot_index", want.slot_index, slot_index);
        check_field("slot_chars", want.chars, slot_chars);
        check_field("slot_length", want.length, slot_length);
        check_field("slot_occupied", want.occupied, slot_occupied);
    endfunction

    // result side: random stalls, one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                take_result();
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !quiet_phase && $urandom_range(99) < 25)
                stall_left = idle_length();
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // drive one beat and wait for it to be taken; valid stays high on return
    task automatic send_item(input logic k, input logic [CHARS_W-1:0] chars,
                             input logic [LEN_W-1:0] len, input logic [7:0] rslot,
                             input logic hand_checked, input result_t want);
        result_t predicted;
        item_valid  <= 1'b1;
        kind        <= k;
        word_chars  <= chars;
        word_length <= len;
        read_slot   <= rslot;
        do
            @(posedge clk);
        while (!item_ready);
        predicted = table_outcome(k, chars, len, rslot);
        if (hand_checked)
            predicted = want;
        expected_results = {expected_results, predicted};
    endtask

    task automatic idle_sender();
        int gap;
        gap = (!quiet_phase && $urandom_range(99) < 40) ? idle_length() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results(input int limit);
        int waited;
        waited = 0;
        item_valid <= 1'b0;
        while (expected_results.size() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_ADDR;
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_setting = value;
    endtask

    initial
    begin
        int phase;
        int n;
        int r;
        logic k;
        logic [CHARS_W-1:0] chars;
        logic [LEN_W-1:0] len;
        logic [7:0] rslot;
        logic [SIZE_W-1:0] size_val;

        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        item_valid  <= 1'b0;
        kind        <= KIND_INSERT;
        word_chars  <= '0;
        word_length <= '0;
        read_slot   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (n = 0; n < NUM_DIRECTED; n++)
        begin
            send_item(directed_rows[n].kind, directed_rows[n].chars, directed_rows[n].length,
                      directed_rows[n].read_slot, directed_rows[n].hand_checked,
                      directed_rows[n].want);
            idle_sender();
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_results(DRAIN_LIMIT);
            repeat (4) @(posedge clk);
            size_val = (phase == 8) ? SIZE_W'($urandom_range(3, 255)) : phase_sizes[phase];
            write_size(size_val);
            quiet_phase = (phase % 4 == 2);
            // receiver holds off while beats keep coming, so the input backs up
            if (phase == 3)
                long_hold_req = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 5 && n == ITEMS_PER_PHASE / 2)
                    wait_for_results(DRAIN_LIMIT);
                r     = $urandom_range(99);
                chars = {$urandom, $urandom};
                rslot = 8'($urandom);
                len   = ($urandom_range(99) < 12) ? LEN_W'($urandom_range(9, 15))
                                                  : LEN_W'($urandom_range(1, 8));
                k     = KIND_INSERT;
                if (r < 30 && taken_slots.size() != 0)
                begin
                    // reads only hit slots that hold a word
                    k     = KIND_READ;
                    rslot = 8'(taken_slots[$urandom_range(taken_slots.size() - 1)]);
                    len   = LEN_W'($urandom);
                end
                else if (r < 36)
                    len = '0;
                else if (r < 44)
                    chars = '1;
                else if (r < 52)
                    chars = chars & 64'h0303_0303_0303_0303;
                send_item(k, chars, len, rslot, 1'b0, NO_RESULT);
                idle_sender();
            end
        end

        quiet_phase = 1'b0;
        wait_for_results(DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("additive_hash_linear_probe_table_top regression: pass");
        else
            $display("additive_hash_linear_probe_table_top regression: fail");
        $finish;
    end

endmodule
